// ===== hw/rtl/whc_pkg.sv =====
`default_nettype none

package whc_pkg;

  // actions carried by an input item
  localparam logic [2:0] ACT_START  = 3'd0;
  localparam logic [2:0] ACT_CLEAR  = 3'd1;
  localparam logic [2:0] ACT_ADD    = 3'd2;
  localparam logic [2:0] ACT_UPDATE = 3'd3;
  localparam logic [2:0] ACT_QUERY  = 3'd4;
  localparam logic [2:0] ACT_LOAD   = 3'd5;

  // register indexes, paddr[3:2]
  localparam logic [1:0] REG_MAX_DIFF    = 2'd0;
  localparam logic [1:0] REG_USE_PRIORS  = 2'd1;
  localparam logic [1:0] REG_PRIOR_COUNT = 2'd2;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [15:0] MAX_DIFF_RST = 16'd655;
  localparam logic [31:0] ACC_MAX      = 32'hFFFF_FFFF;
  localparam int          FRAC_BITS    = 16;
  localparam logic [16:0] FRAC_ONE     = 17'h1_0000;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  bin;
    logic [15:0] weight;
    logic [15:0] prior_value;
  } req_t;

  typedef struct packed {
    logic        changed;
    logic [16:0] fraction;
    logic        saturated;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/weighted_histogram_convergence.sv =====
`default_nettype none

// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+------------------------------
// req       | in        | req_valid / req_stall     | whc_pkg::req_t (one action)
// rsp       | out       | rsp_valid / rsp_stall     | whc_pkg::rsp_t (one per item)
// apb       | in        | psel, penable, pready = 1 | max_diff, use_priors, prior_count
//
// one item at a time; add, load prior and a query with a saturated or zero answer do
// one memory read, then write-back or result; a full query goes on through the
// bit-serial divider; start and clear sweep the pending memory one bin a cycle; update
// forms the threshold, then runs the compare sweep and, when it commits, a copy sweep,
// one bin a cycle through both memory ports
// after reset a clearing pass fills both memories, req_stall high
// a finished item waits in the output register while the next item is taken in; a
// further result waits in a hold register until rsp_stall drops

module weighted_histogram_convergence #(
  parameter int NUM_BINS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire whc_pkg::req_t                 req,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output whc_pkg::rsp_t                      rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [whc_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [whc_pkg::DATA_W-1:0]    pwdata,
  output logic [whc_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  localparam int IW = $clog2(NUM_BINS);
  localparam int CW = $clog2(NUM_BINS + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(NUM_BINS);
  localparam logic [CW-1:0] CNT_LAST = CW'(NUM_BINS - 1);
  localparam logic [3:0]    DIV_LAST = 4'(whc_pkg::FRAC_BITS - 1);

  // controller states
  localparam logic [3:0] ST_CLR      = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_RMW      = 4'd2;
  localparam logic [3:0] ST_SEED     = 4'd3;
  localparam logic [3:0] ST_UPD_TT   = 4'd4;
  localparam logic [3:0] ST_UPD_R    = 4'd5;
  localparam logic [3:0] ST_UPD_THR  = 4'd6;
  localparam logic [3:0] ST_UPD_SUM  = 4'd7;
  localparam logic [3:0] ST_COPY     = 4'd8;
  localparam logic [3:0] ST_QRY      = 4'd9;
  localparam logic [3:0] ST_DIV      = 4'd10;
  localparam logic [3:0] ST_HOLD     = 4'd11;

  // configuration registers
  logic [15:0] max_diff;
  logic        use_priors;
  logic [15:0] prior_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_diff    <= whc_pkg::MAX_DIFF_RST;
      use_priors  <= 1'b0;
      prior_count <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        whc_pkg::REG_MAX_DIFF:    max_diff    <= pwdata[15:0];
        whc_pkg::REG_USE_PRIORS:  use_priors  <= pwdata[0];
        whc_pkg::REG_PRIOR_COUNT: prior_count <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      whc_pkg::REG_MAX_DIFF:    prdata = {16'd0, max_diff};
      whc_pkg::REG_USE_PRIORS:  prdata = {31'd0, use_priors};
      whc_pkg::REG_PRIOR_COUNT: prdata = {16'd0, prior_count};
      default:                  prdata = '0;
    endcase
  end

  // pending memory: [47:32] prior table entry, [31:0] pending bin
  // committed memory: committed bin
  logic [47:0] mem_a [NUM_BINS];
  logic [31:0] mem_b [NUM_BINS];
  logic [IW-1:0] ra;
  logic          we_a, we_b;
  logic [IW-1:0] wa_a, wa_b;
  logic [47:0]   wd_a;
  logic [31:0]   wd_b;
  logic [47:0]   rd_a;
  logic [31:0]   rd_b;

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wa_a] <= wd_a;
    end
    rd_a <= mem_a[ra];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wa_b] <= wd_b;
    end
    rd_b <= mem_b[ra];
  end

  // control and datapath registers
  logic [3:0]    state;
  logic [CW-1:0] cnt;
  logic [IW-1:0] widx;
  logic          v1, v2, v3;
  logic          moved;
  logic          seed_zero;
  logic [31:0]   ctotal;
  logic [31:0]   ptotal;
  whc_pkg::req_t cur;
  logic          cur_in;
  whc_pkg::rsp_t res;
  logic [63:0]   tt;
  logic [47:0]   rlo, rhi;
  logic [79:0]   thr;
  logic [63:0]   p, q, d;
  logic [31:0]   rem;
  logic [14:0]   quo;
  logic [3:0]    dcnt;

  logic          out_free;
  logic          iss;
  logic          done_sweep;
  logic          fin;
  whc_pkg::rsp_t fin_rsp;
  logic [32:0]   add_sum, tot_sum;
  logic [31:0]   add_bin, add_tot;
  logic [31:0]   seed_val;
  logic [32:0]   rem2, rem_sub;
  logic          ge;
  logic          req_in;

  assign req_stall  = (state != ST_IDLE);
  assign out_free   = !rsp_valid || !rsp_stall;
  assign iss        = (cnt != CNT_END);
  assign done_sweep = !iss && !v1 && !v2 && !v3;
  assign req_in     = ({28'd0, req.bin} < 32'(NUM_BINS));

  // saturating accumulate for add
  assign add_sum = {1'b0, rd_a[31:0]} + 33'(cur.weight);
  assign tot_sum = {1'b0, ptotal} + 33'(cur.weight);
  assign add_bin = (add_sum >= 33'(whc_pkg::ACC_MAX)) ? whc_pkg::ACC_MAX : add_sum[31:0];
  assign add_tot = (tot_sum >= 33'(whc_pkg::ACC_MAX)) ? whc_pkg::ACC_MAX : tot_sum[31:0];

  // prior entry scaled by the prior count, fits 32 bits
  assign seed_val = seed_zero ? '0 : 32'(rd_a[47:32]) * 32'(prior_count);

  // one quotient bit a cycle, remainder stays below the committed total
  assign rem2    = {rem, 1'b0};
  assign rem_sub = rem2 - {1'b0, ctotal};
  assign ge      = (rem2 >= {1'b0, ctotal});

  // memory port control
  always_comb begin
    ra   = (state == ST_IDLE) ? IW'(req.bin) : cnt[IW-1:0];
    we_a = 1'b0;
    we_b = 1'b0;
    wa_a = widx;
    wa_b = widx;
    wd_a = '0;
    wd_b = '0;
    case (state)
      ST_CLR: begin
        we_a = 1'b1;
        we_b = 1'b1;
        wa_a = cnt[IW-1:0];
        wa_b = cnt[IW-1:0];
        wd_b = 32'd1;
      end
      ST_RMW: begin
        wa_a = IW'(cur.bin);
        we_a = cur_in;
        if (cur.action == whc_pkg::ACT_LOAD) begin
          wd_a = {cur.prior_value, rd_a[31:0]};
        end else begin
          wd_a = {rd_a[47:32], add_bin};
        end
      end
      ST_SEED: begin
        we_a = v1;
        wd_a = {rd_a[47:32], seed_val};
      end
      ST_COPY: begin
        we_b = v1;
        wd_b = rd_a[31:0];
      end
      default: ;
    endcase
  end

  // result of the item in progress, when it is ready
  always_comb begin
    fin     = 1'b0;
    fin_rsp = '0;
    case (state)
      ST_RMW: begin
        fin = 1'b1;
        fin_rsp.saturated = cur_in && (cur.action == whc_pkg::ACT_ADD) &&
                            ((add_bin == whc_pkg::ACC_MAX) || (add_tot == whc_pkg::ACC_MAX));
      end
      ST_SEED: fin = !iss && !v1;
      ST_UPD_SUM: fin = done_sweep && !moved;
      ST_COPY: begin
        fin = !iss && !v1;
        fin_rsp.changed = 1'b1;
      end
      ST_QRY: begin
        fin = !(cur_in && (ctotal != '0) && (rd_b < ctotal));
        if (cur_in && (ctotal != '0)) begin
          fin_rsp.fraction = whc_pkg::FRAC_ONE;
        end
      end
      ST_DIV: begin
        fin = (dcnt == DIV_LAST);
        fin_rsp.fraction = {1'b0, quo, ge};
      end
      ST_HOLD: begin
        fin     = 1'b1;
        fin_rsp = res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      cnt       <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      moved     <= 1'b0;
      rsp_valid <= 1'b0;
      ctotal    <= 32'(NUM_BINS);
      ptotal    <= '0;
    end else begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      // hand the result to the output register, or park it
      if (fin) begin
        if (out_free) begin
          rsp       <= fin_rsp;
          rsp_valid <= 1'b1;
          state     <= ST_IDLE;
        end else begin
          res   <= fin_rsp;
          state <= ST_HOLD;
        end
      end
      case (state)
        ST_CLR: begin
          cnt <= cnt + CW'(1);
          if (cnt == CNT_LAST) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            cur    <= req;
            cur_in <= req_in;
            cnt    <= '0;
            moved  <= 1'b0;
            res    <= '0;
            case (req.action)
              whc_pkg::ACT_START: begin
                seed_zero <= !use_priors;
                ptotal    <= use_priors ? {prior_count, 16'd0} : '0;
                state     <= ST_SEED;
              end
              whc_pkg::ACT_CLEAR: begin
                seed_zero <= 1'b1;
                ptotal    <= '0;
                state     <= ST_SEED;
              end
              whc_pkg::ACT_ADD, whc_pkg::ACT_LOAD: state <= ST_RMW;
              whc_pkg::ACT_UPDATE: begin
                // a fraction over a zero total is undefined, no compare then
                if ((ctotal != '0) && (ptotal != '0)) begin
                  state <= ST_UPD_TT;
                end else begin
                  state <= ST_HOLD;
                end
              end
              whc_pkg::ACT_QUERY: state <= ST_QRY;
              default: state <= ST_HOLD;
            endcase
          end
        end
        ST_RMW: begin
          if (cur_in && (cur.action == whc_pkg::ACT_ADD)) begin
            ptotal <= add_tot;
          end
        end
        ST_SEED, ST_COPY: begin
          v1   <= iss;
          widx <= cnt[IW-1:0];
          if (iss) begin
            cnt <= cnt + CW'(1);
          end
          if ((state == ST_COPY) && !iss && !v1) begin
            ctotal <= ptotal;
          end
        end
        ST_UPD_TT: begin
          tt    <= 64'(ctotal) * 64'(ptotal);
          state <= ST_UPD_R;
        end
        ST_UPD_R: begin
          rlo   <= 48'(tt[31:0]) * 48'(max_diff);
          rhi   <= 48'(tt[63:32]) * 48'(max_diff);
          state <= ST_UPD_THR;
        end
        ST_UPD_THR: begin
          // threshold scaled by both totals, compared against the cross-product gap
          thr   <= {rhi, 32'd0} + 80'(rlo);
          state <= ST_UPD_SUM;
        end
        ST_UPD_SUM: begin
          v1 <= iss;
          v2 <= v1;
          v3 <= v2;
          if (iss) begin
            cnt <= cnt + CW'(1);
          end
          if (v1) begin
            p <= 64'(rd_b) * 64'(ptotal);
            q <= 64'(rd_a[31:0]) * 64'(ctotal);
          end
          if (v2) begin
            d <= (p > q) ? p - q : q - p;
          end
          if (v3 && ({d, 16'd0} > thr)) begin
            moved <= 1'b1;
          end
          if (done_sweep && moved) begin
            cnt   <= '0;
            state <= ST_COPY;
          end
        end
        ST_QRY: begin
          if (!fin) begin
            rem   <= rd_b;
            quo   <= '0;
            dcnt  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= ge ? rem_sub[31:0] : rem2[31:0];
          quo  <= {quo[13:0], ge};
          dcnt <= dcnt + 4'd1;
        end
        ST_HOLD: ;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/whc_checker.sv =====
`default_nettype none

module whc_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire whc_pkg::rsp_t rsp
);

  // a waiting result holds still
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result dropped or changed while stalled");

  // clearing pass follows reset, no item taken in its first cycle
  assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> req_stall)
    else $error("item taken during clearing pass");

  // an item taken in makes the block stall in the cycle after
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("item taken while previous one still in progress");

  // a fraction never exceeds one and comes with no other flag
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.fraction != '0) |->
      (rsp.fraction <= whc_pkg::FRAC_ONE) && !rsp.changed && !rsp.saturated)
    else $error("malformed query result");

endmodule

bind weighted_histogram_convergence whc_checker u_whc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

// ===== bench/weighted_histogram_convergence_tb.sv =====
// scoreboard: keeps its own copy of both histograms, the prior table and the
// registers, and queues one expected result per accepted item
class histogram_scoreboard;
  localparam int HIST_BINS = 16;

  logic [15:0] max_diff;
  logic        use_priors;
  logic [15:0] prior_count;

  logic [31:0] committed_bins [HIST_BINS];
  logic [31:0] committed_total;
  logic [31:0] pending_bins [HIST_BINS];
  logic [31:0] pending_total;
  logic [15:0] prior_table [HIST_BINS];
  logic        committed_flag;

  whc_pkg::rsp_t expected_q[$];
  int errors;
  int checked;
  int commits;
  int saturations;

  function new();
    max_diff = whc_pkg::MAX_DIFF_RST;
    use_priors = 1'b0;
    prior_count = '0;
    for (int k = 0; k < HIST_BINS; k++) begin
      committed_bins[k] = 32'd1;
      pending_bins[k] = '0;
      prior_table[k] = '0;
    end
    committed_total = HIST_BINS;
    pending_total = '0;
    committed_flag = 1'b0;
    errors = 0;
    checked = 0;
    commits = 0;
    saturations = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] value);
    case (idx)
      whc_pkg::REG_MAX_DIFF:    max_diff = value[15:0];
      whc_pkg::REG_USE_PRIORS:  use_priors = value[0];
      whc_pkg::REG_PRIOR_COUNT: prior_count = value[15:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // |a/ta - b/tb| > max_diff/65536, all cross-multiplied
  function bit bin_moved(logic [31:0] a, logic [31:0] ta, logic [31:0] b, logic [31:0] tb);
    logic [63:0]  p;
    logic [63:0]  q;
    logic [63:0]  d;
    logic [127:0] lhs;
    logic [127:0] rhs;
    p = {32'b0, a} * {32'b0, tb};
    q = {32'b0, b} * {32'b0, ta};
    d = (p > q) ? p - q : q - p;
    lhs = {64'b0, d} << 16;
    rhs = {112'b0, max_diff} * {96'b0, ta} * {96'b0, tb};
    return lhs > rhs;
  endfunction

  function void note_item(whc_pkg::req_t r);
    whc_pkg::rsp_t e;
    logic [32:0]   sum;
    logic [47:0]   quot;
    bit            moved;
    e = '0;
    moved = 1'b0;
    case (r.action)
      whc_pkg::ACT_START: begin
        for (int k = 0; k < HIST_BINS; k++)
          pending_bins[k] = use_priors ? {16'b0, prior_table[k]} * {16'b0, prior_count} : '0;
        pending_total = use_priors ? {prior_count, 16'b0} : '0;
      end
      whc_pkg::ACT_CLEAR: begin
        for (int k = 0; k < HIST_BINS; k++) pending_bins[k] = '0;
        pending_total = '0;
        committed_flag = 1'b0;
      end
      whc_pkg::ACT_ADD: begin
        // bin and total saturate independently, either one flags the item
        sum = {1'b0, pending_bins[r.bin]} + r.weight;
        if (sum >= {1'b0, whc_pkg::ACC_MAX}) begin
          e.saturated = 1'b1;
          pending_bins[r.bin] = whc_pkg::ACC_MAX;
        end else begin
          pending_bins[r.bin] = sum[31:0];
        end
        sum = {1'b0, pending_total} + r.weight;
        if (sum >= {1'b0, whc_pkg::ACC_MAX}) begin
          e.saturated = 1'b1;
          pending_total = whc_pkg::ACC_MAX;
        end else begin
          pending_total = sum[31:0];
        end
      end
      whc_pkg::ACT_UPDATE: begin
        if ((!committed_flag || pending_total != 0) && committed_total != 0 &&
            pending_total != 0) begin
          for (int k = 0; k < HIST_BINS; k++)
            if (bin_moved(committed_bins[k], committed_total, pending_bins[k], pending_total))
              moved = 1'b1;
        end
        if (moved) begin
          for (int k = 0; k < HIST_BINS; k++) committed_bins[k] = pending_bins[k];
          committed_total = pending_total;
          committed_flag = 1'b1;
          e.changed = 1'b1;
        end
      end
      whc_pkg::ACT_QUERY: begin
        if (committed_total != 0) begin
          quot = {committed_bins[r.bin], 16'b0} / {16'b0, committed_total};
          e.fraction = (quot > 48'd65536) ? whc_pkg::FRAC_ONE : quot[16:0];
        end
      end
      whc_pkg::ACT_LOAD: prior_table[r.bin] = r.prior_value;
      default: ;
    endcase
    expected_q.push_back(e);
  endfunction

  function void check_result(whc_pkg::rsp_t got);
    whc_pkg::rsp_t want;
    if (expected_q.size() == 0) begin
      $error("result with no item outstanding: changed %0d fraction %0d saturated %0d",
             got.changed, got.fraction, got.saturated);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    checked++;
    commits += want.changed;
    saturations += want.saturated;
    if (got.changed !== want.changed) begin
      $error("changed: expected %0d, got %0d", want.changed, got.changed);
      errors++;
    end
    if (got.fraction !== want.fraction) begin
      $error("fraction: expected %0d, got %0d", want.fraction, got.fraction);
      errors++;
    end
    if (got.saturated !== want.saturated) begin
      $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
      errors++;
    end
  endfunction
endclass

module weighted_histogram_convergence_tb;

  localparam int NUM_BINS = 16;
  // actions the block leaves alone
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  // random items per register setting
  localparam int PHASE_ITEMS = 225;
  localparam int NUM_PHASES = 8;
  // output hold that backs the block up into its input
  localparam int HOLD_CYCLES = 300;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_stall;
  whc_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_stall;
  whc_pkg::rsp_t rsp;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [whc_pkg::ADDR_W-1:0] paddr;
  logic [whc_pkg::DATA_W-1:0] pwdata;
  logic [whc_pkg::DATA_W-1:0] prdata;
  logic          pready;

  histogram_scoreboard sb = new();

  // shared between the sender and the receiver
  bit quiet = 1'b0;      // no idling on either side
  bit hold_req = 1'b0;   // ask the receiver for one long hold
  int phase_items;
  int items_sent = 0;

  // last pass's adds, kept so that a pass can be replayed and converge
  logic [3:0]  add_bins[$];
  logic [15:0] add_weights[$];

  weighted_histogram_convergence #(.NUM_BINS(NUM_BINS)) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // both handshakes sampled at the edge, before that edge's updates land
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_item(req);
      if (rsp_valid && !rsp_stall) sb.check_result(rsp);
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
      end else if (!quiet && !rst && $urandom_range(0, 7) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // register write: setup cycle, access cycle, then the bus goes quiet
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  // offer one item, maybe after an idle burst, and hold it until taken
  task automatic send_op(input logic [2:0] act, input logic [3:0] b,
                         input logic [15:0] w, input logic [15:0] pv);
    whc_pkg::req_t r;
    r.action = act;
    r.bin = b;
    r.weight = w;
    r.prior_value = pv;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (act <= whc_pkg::ACT_LOAD) begin
      phase_items++;
      items_sent++;
    end
  endtask

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 3))
      0: return 16'hFFFF;
      1: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_noise();
    send_op($urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI, 4'($urandom),
            16'($urandom), 16'($urandom));
  endtask

  // the two unused action codes, all fields high then all low
  task automatic send_ops_spare();
    send_op(ACT_SPARE_HI, 4'hF, 16'hFFFF, 16'hFFFF);
    send_op(ACT_SPARE_LO, 4'd0, 16'd0, 16'd0);
  endtask

  // one pass: optional prior loads, a start, a clear or neither, a run of adds, update, queries
  task automatic run_pass();
    int kind;
    int n;
    int k;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4))
        send_op(whc_pkg::ACT_LOAD, 4'($urandom), 16'($urandom), rand_weight());
    if (kind < 6)
      send_op(whc_pkg::ACT_START, 4'($urandom), 16'($urandom), 16'($urandom));
    else if (kind < 8)
      send_op(whc_pkg::ACT_CLEAR, 4'($urandom), 16'($urandom), 16'($urandom));
    if (add_bins.size() > 0 && $urandom_range(0, 3) == 0) begin
      // replay the last pass so the fractions settle, sometimes nudged a little
      if ($urandom_range(0, 1) == 1) begin
        k = $urandom_range(0, add_bins.size() - 1);
        add_weights[k] = add_weights[k] + 16'($urandom_range(1, 64));
      end
    end else begin
      add_bins.delete();
      add_weights.delete();
      n = $urandom_range(1, 16);
      repeat (n) begin
        // a few hot bins keep the distribution lumpy
        add_bins.push_back($urandom_range(0, 2) != 0 ? 4'($urandom_range(0, 3))
                                                     : 4'($urandom));
        add_weights.push_back(rand_weight());
      end
    end
    foreach (add_bins[i]) begin
      if ($urandom_range(0, 11) == 0) send_noise();
      send_op(whc_pkg::ACT_ADD, add_bins[i], add_weights[i], 16'($urandom));
    end
    send_op(whc_pkg::ACT_UPDATE, 4'($urandom), 16'($urandom), 16'($urandom));
    repeat ($urandom_range(0, 3))
      send_op(whc_pkg::ACT_QUERY, 4'($urandom), 16'($urandom), 16'($urandom));
    if ($urandom_range(0, 3) == 0)
      send_op(whc_pkg::ACT_UPDATE, 4'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    req_valid <= 1'b0;
    req <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      phase_items = 0;
      // registers only change with nothing in flight
      case (p)
        1: begin
          write_reg(whc_pkg::REG_MAX_DIFF, 32'd0);
          write_reg(whc_pkg::REG_USE_PRIORS, 32'd1);
          write_reg(whc_pkg::REG_PRIOR_COUNT, 32'd65535);
        end
        2: begin
          write_reg(whc_pkg::REG_MAX_DIFF, 32'd65535);
          write_reg(whc_pkg::REG_USE_PRIORS, 32'd0);
          write_reg(whc_pkg::REG_PRIOR_COUNT, 32'd0);
        end
        3: begin
          write_reg(whc_pkg::REG_MAX_DIFF, $urandom_range(0, 2000));
          write_reg(whc_pkg::REG_USE_PRIORS, 32'd1);
          write_reg(whc_pkg::REG_PRIOR_COUNT, $urandom_range(1, 16));
        end
        4: begin
          write_reg(whc_pkg::REG_MAX_DIFF, 32'(whc_pkg::MAX_DIFF_RST));
          write_reg(whc_pkg::REG_USE_PRIORS, 32'd1);
          write_reg(whc_pkg::REG_PRIOR_COUNT, 32'd0);
          hold_req = 1'b1;
        end
        5: begin
          write_reg(whc_pkg::REG_MAX_DIFF, $urandom_range(0, 65535));
          write_reg(whc_pkg::REG_USE_PRIORS, 32'd0);
          write_reg(whc_pkg::REG_PRIOR_COUNT, $urandom_range(0, 65535));
        end
        6: begin
          write_reg(whc_pkg::REG_MAX_DIFF, 32'd1);
          write_reg(whc_pkg::REG_USE_PRIORS, 32'd1);
          write_reg(whc_pkg::REG_PRIOR_COUNT, 32'd1);
        end
        7: begin
          write_reg(whc_pkg::REG_MAX_DIFF, $urandom_range(0, 1000));
          write_reg(whc_pkg::REG_USE_PRIORS, $urandom_range(0, 1));
          write_reg(whc_pkg::REG_PRIOR_COUNT, $urandom_range(0, 300));
          quiet = 1'b1;
        end
        default: ;
      endcase

      if (p == 0) begin
        // reset histogram: every bin one sixteenth
        send_op(whc_pkg::ACT_QUERY, 4'd0, 16'd0, 16'd0);
        send_op(whc_pkg::ACT_QUERY, 4'd15, 16'hFFFF, 16'hFFFF);
        // empty pending histogram, comparison skipped
        send_op(whc_pkg::ACT_UPDATE, 4'd0, 16'd0, 16'd0);
        send_op(whc_pkg::ACT_ADD, 4'd0, 16'd0, 16'hFFFF);
        send_op(whc_pkg::ACT_UPDATE, 4'd0, 16'd0, 16'd0);
        // lopsided pass commits
        send_op(whc_pkg::ACT_ADD, 4'd3, 16'hFFFF, 16'd0);
        send_op(whc_pkg::ACT_ADD, 4'd15, 16'd1, 16'd0);
        send_op(whc_pkg::ACT_UPDATE, 4'd0, 16'd0, 16'd0);
        send_op(whc_pkg::ACT_QUERY, 4'd3, 16'd0, 16'd0);
        send_op(whc_pkg::ACT_QUERY, 4'd15, 16'd0, 16'd0);
        send_op(whc_pkg::ACT_QUERY, 4'd0, 16'd0, 16'd0);
        // identical pending histogram, no change
        send_op(whc_pkg::ACT_UPDATE, 4'd0, 16'd0, 16'd0);
        // empty pass after a commit is skipped
        send_op(whc_pkg::ACT_START, 4'd0, 16'd0, 16'd0);
        send_op(whc_pkg::ACT_UPDATE, 4'd0, 16'd0, 16'd0);
        send_op(whc_pkg::ACT_CLEAR, 4'hF, 16'hFFFF, 16'hFFFF);
        send_op(whc_pkg::ACT_UPDATE, 4'd0, 16'd0, 16'd0);
        // prior table for the next setting
        send_op(whc_pkg::ACT_LOAD, 4'd0, 16'd0, 16'hFFFF);
        send_op(whc_pkg::ACT_LOAD, 4'd15, 16'hFFFF, 16'd0);
        send_ops_spare();
      end else if (p == 1) begin
        // full prior seeding leaves the total just short of saturation
        send_op(whc_pkg::ACT_START, 4'd0, 16'd0, 16'd0);
        send_op(whc_pkg::ACT_ADD, 4'd0, 16'hFFFF, 16'd0);
        send_op(whc_pkg::ACT_ADD, 4'd0, 16'hFFFF, 16'd0);
        send_op(whc_pkg::ACT_UPDATE, 4'd0, 16'd0, 16'd0);
        send_op(whc_pkg::ACT_QUERY, 4'd0, 16'd0, 16'd0);
        send_op(whc_pkg::ACT_QUERY, 4'd1, 16'd0, 16'd0);
      end

      while (phase_items < PHASE_ITEMS) run_pass();

      // sender pauses until every result of this setting is back
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clk);
    end

    repeat (4 * NUM_BINS + 20) @(posedge clk);
    $display("%0d items over %0d register settings, %0d results checked",
             items_sent, NUM_PHASES, sb.checked);
    $display("%0d commits, %0d saturating adds, one %0d-cycle output hold",
             sb.commits, sb.saturations, HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/whc_pkg.sv
hw/rtl/weighted_histogram_convergence.sv
hw/rtl/whc_checker.sv
bench/weighted_histogram_convergence_tb.sv
